>>> hw/rtl/efm_pkg.sv
// Shared definitions for the event flag matcher.
// Operation codes, register indexes, sizes and the status bundle.
// No dependencies.
`timescale 1ns / 1ps

package efm_pkg;

  localparam int EVENT_SLOTS = 6;
  localparam int NUM_EVENTS_DEF = 6;
  localparam int FLAG_WIDTH_DEF = 64;

  localparam int OP_W = 3;
  localparam int IDX_W = 3;

  localparam logic [OP_W-1:0] OP_RAISE  = 3'd0;
  localparam logic [OP_W-1:0] OP_DROP   = 3'd1;
  localparam logic [OP_W-1:0] OP_FORCE  = 3'd2;
  localparam logic [OP_W-1:0] OP_LISTEN = 3'd3;
  localparam logic [OP_W-1:0] OP_CHECK  = 3'd4;
  localparam logic [OP_W-1:0] OP_SNOOP  = 3'd5;

  // Event mask registers sit at indexes 0 up to EVENT_SLOTS-1.
  localparam logic [IDX_W-1:0] REG_EVENT_CONSUMES = 3'd6;

  typedef struct packed {
    logic [EVENT_SLOTS-1:0] fired;
    logic                   single_fired;
    logic                   snoop_hit;
  } status_t;

endpackage

>>> hw/rtl/event_flag_matcher.sv
// Top level of the event flag matcher: input register, update logic, result register.
// Depends on efm_pkg, efm_cfg_regs and efm_exec.
`timescale 1ns / 1ps

// Usage:
//   Input channel in_*: an item (operation, operand mask, consume) transfers at a
//   clock edge with in_valid high and in_stall low. Result channel out_*: one
//   result per item, transferred with out_valid high and out_stall low.
//   Configuration: cfg_wen writes cfg_wdata into register cfg_index (event masks
//   at 0..5, consume bits at 6, other indexes ignored); write only while idle.
// Throughput: one item per cycle while out_stall is low; all work runs in the
//   single stage between the input register and the result register, with the
//   flag state updated as the item leaves the input register.
// Stall: while the result register is full and out_stall is high, the stage
//   holds; the input register still takes one more item and then raises in_stall.
// Reset (rst_n low, synchronous): both registers empty, flags zero, pending
//   change cleared, all configuration registers zero.

module event_flag_matcher #(
  parameter int NUM_EVENTS = efm_pkg::NUM_EVENTS_DEF,
  parameter int FLAG_WIDTH = efm_pkg::FLAG_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [efm_pkg::OP_W-1:0]         in_operation,
  input  logic [FLAG_WIDTH-1:0]            in_operand_mask,
  input  logic                             in_consume,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [FLAG_WIDTH-1:0]            out_flags_out,
  output logic [efm_pkg::EVENT_SLOTS-1:0]  out_fired,
  output logic                             out_single_fired,
  output logic                             out_snoop_hit,
  input  logic                             cfg_wen,
  input  logic [efm_pkg::IDX_W-1:0]        cfg_index,
  input  logic [FLAG_WIDTH-1:0]            cfg_wdata
);

  logic                                  in_vld_r;
  logic [efm_pkg::OP_W-1:0]              op_r;
  logic [FLAG_WIDTH-1:0]                 mask_r;
  logic                                  cons_r;
  logic                                  out_vld_r;
  logic [FLAG_WIDTH-1:0]                 flags_out_r;
  efm_pkg::status_t                      status_r;
  logic                                  advance;
  logic                                  step;
  logic [FLAG_WIDTH-1:0]                 flags_nxt;
  efm_pkg::status_t                      status_nxt;
  logic [NUM_EVENTS-1:0][FLAG_WIDTH-1:0] event_mask;
  logic [NUM_EVENTS-1:0]                 event_consumes;

  assign advance  = !out_vld_r || !out_stall;
  assign step     = in_vld_r && advance;
  assign in_stall = in_vld_r && !advance;

  efm_cfg_regs #(
    .NUM_EVENTS(NUM_EVENTS),
    .FLAG_WIDTH(FLAG_WIDTH)
  ) u_cfg (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_wen       (cfg_wen),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .event_mask    (event_mask),
    .event_consumes(event_consumes)
  );

  efm_exec #(
    .NUM_EVENTS(NUM_EVENTS),
    .FLAG_WIDTH(FLAG_WIDTH)
  ) u_exec (
    .clk           (clk),
    .rst_n         (rst_n),
    .step          (step),
    .operation     (op_r),
    .operand_mask  (mask_r),
    .consume       (cons_r),
    .event_mask    (event_mask),
    .event_consumes(event_consumes),
    .flags_nxt     (flags_nxt),
    .status        (status_nxt)
  );

  // Input register: refill whenever it is empty or drains this cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (!in_stall) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      op_r   <= in_operation;
      mask_r <= in_operand_mask;
      cons_r <= in_consume;
    end
  end

  // Result register: hold while the receiver stalls.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= in_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      flags_out_r <= flags_nxt;
      status_r    <= status_nxt;
    end
  end

  assign out_valid        = out_vld_r;
  assign out_flags_out    = flags_out_r;
  assign out_fired        = status_r.fired;
  assign out_single_fired = status_r.single_fired;
  assign out_snoop_hit    = status_r.snoop_hit;

endmodule

>>> hw/rtl/efm_cfg_regs.sv
// Configuration registers of the event flag matcher: event masks and consume bits.
// Depends on efm_pkg.
`timescale 1ns / 1ps

module efm_cfg_regs #(
  parameter int NUM_EVENTS = efm_pkg::NUM_EVENTS_DEF,
  parameter int FLAG_WIDTH = efm_pkg::FLAG_WIDTH_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_wen,
  input  logic [efm_pkg::IDX_W-1:0]             cfg_index,
  input  logic [FLAG_WIDTH-1:0]                 cfg_wdata,
  output logic [NUM_EVENTS-1:0][FLAG_WIDTH-1:0] event_mask,
  output logic [NUM_EVENTS-1:0]                 event_consumes
);

  logic [NUM_EVENTS-1:0][FLAG_WIDTH-1:0] event_mask_r;
  logic [NUM_EVENTS-1:0]                 consumes_r;

  // Slots at or above NUM_EVENTS never fire, so their writes are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      event_mask_r <= '0;
      consumes_r   <= '0;
    end else if (cfg_wen) begin
      for (int i = 0; i < NUM_EVENTS; i++) begin
        if (cfg_index == efm_pkg::IDX_W'(i)) begin
          event_mask_r[i] <= cfg_wdata;
        end
      end
      if (cfg_index == efm_pkg::REG_EVENT_CONSUMES) begin
        consumes_r <= cfg_wdata[NUM_EVENTS-1:0];
      end
    end
  end

  assign event_mask     = event_mask_r;
  assign event_consumes = consumes_r;

endmodule

>>> hw/rtl/efm_exec.sv
// Flag state and per-item update logic of the event flag matcher.
// Holds flags and the pending keep/set masks. Depends on efm_pkg.
`timescale 1ns / 1ps

module efm_exec #(
  parameter int NUM_EVENTS = efm_pkg::NUM_EVENTS_DEF,
  parameter int FLAG_WIDTH = efm_pkg::FLAG_WIDTH_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  step,
  input  logic [efm_pkg::OP_W-1:0]              operation,
  input  logic [FLAG_WIDTH-1:0]                 operand_mask,
  input  logic                                  consume,
  input  logic [NUM_EVENTS-1:0][FLAG_WIDTH-1:0] event_mask,
  input  logic [NUM_EVENTS-1:0]                 event_consumes,
  output logic [FLAG_WIDTH-1:0]                 flags_nxt,
  output efm_pkg::status_t                      status
);

  logic [FLAG_WIDTH-1:0] flags_r;
  logic [FLAG_WIDTH-1:0] keep_r;
  logic [FLAG_WIDTH-1:0] set_r;
  logic [FLAG_WIDTH-1:0] keep_nxt;
  logic [FLAG_WIDTH-1:0] set_nxt;
  logic [FLAG_WIDTH-1:0] work;

  always_comb begin
    flags_nxt = flags_r;
    keep_nxt  = keep_r;
    set_nxt   = set_r;
    status    = '0;
    work      = flags_r;
    case (operation)
      efm_pkg::OP_RAISE: begin
        set_nxt  = set_r | operand_mask;
        keep_nxt = keep_r | operand_mask;
      end
      efm_pkg::OP_DROP: begin
        set_nxt  = set_r & ~operand_mask;
        keep_nxt = keep_r & ~operand_mask;
      end
      efm_pkg::OP_FORCE: begin
        flags_nxt = operand_mask;
        keep_nxt  = '1;
        set_nxt   = '0;
      end
      efm_pkg::OP_LISTEN: begin
        // Walk the table in order; a consuming event hides its bits from later ones.
        for (int i = 0; i < NUM_EVENTS; i++) begin
          if ((event_mask[i] != '0) && ((work & event_mask[i]) == event_mask[i])) begin
            status.fired[i] = 1'b1;
            if (event_consumes[i]) begin
              work = work & ~event_mask[i];
            end
          end
        end
        flags_nxt = (work & keep_r) | set_r;
        keep_nxt  = '1;
        set_nxt   = '0;
      end
      efm_pkg::OP_CHECK: begin
        if ((operand_mask != '0) && ((flags_r & operand_mask) == operand_mask)) begin
          status.single_fired = 1'b1;
          if (consume) begin
            flags_nxt = flags_r & ~operand_mask;
          end
        end
        keep_nxt = '1;
        set_nxt  = '0;
      end
      efm_pkg::OP_SNOOP: begin
        status.snoop_hit = ((flags_r & operand_mask) == operand_mask);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flags_r <= '0;
      keep_r  <= '1;
      set_r   <= '0;
    end else if (step) begin
      flags_r <= flags_nxt;
      keep_r  <= keep_nxt;
      set_r   <= set_nxt;
    end
  end

endmodule

>>> test/efm_checker.sv
// Result checker for the event flag matcher: watches the config port and both channels.
// Predicts each result from its own copy of the flag state; depends on efm_pkg.
`timescale 1ns / 1ps

module efm_checker
  import efm_pkg::*;
#(
  parameter int NUM_EVENTS = NUM_EVENTS_DEF,
  parameter int FLAG_WIDTH = FLAG_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  input  logic                   in_stall,
  input  logic [OP_W-1:0]        in_operation,
  input  logic [FLAG_WIDTH-1:0]  in_operand_mask,
  input  logic                   in_consume,
  input  logic                   out_valid,
  input  logic                   out_stall,
  input  logic [FLAG_WIDTH-1:0]  out_flags_out,
  input  logic [EVENT_SLOTS-1:0] out_fired,
  input  logic                   out_single_fired,
  input  logic                   out_snoop_hit,
  input  logic                   cfg_wen,
  input  logic [IDX_W-1:0]       cfg_index,
  input  logic [FLAG_WIDTH-1:0]  cfg_wdata,
  output int unsigned            fail_cnt = 0,
  output int unsigned            done_cnt = 0,
  output int unsigned            open_cnt = 0
);

  typedef struct packed {
    logic [FLAG_WIDTH-1:0]  flags;
    logic [EVENT_SLOTS-1:0] fired;
    logic                   single_hit;
    logic                   snoop_hit;
  } flag_result_t;

  logic [FLAG_WIDTH-1:0]  ev_mask [EVENT_SLOTS];
  logic [EVENT_SLOTS-1:0] ev_consume;
  logic [FLAG_WIDTH-1:0]  flag_word;
  logic [FLAG_WIDTH-1:0]  chg_keep;
  logic [FLAG_WIDTH-1:0]  chg_set;

  flag_result_t awaited [$];
  int unsigned  faults = 0;
  int unsigned  results_seen = 0;

  task automatic note_fault(input string what, input logic [FLAG_WIDTH-1:0] want_v,
                            input logic [FLAG_WIDTH-1:0] got_v);
    faults++;
    $display("%0t: %s mismatch: expected %h, got %h", $time, what, want_v, got_v);
  endtask

  // Advance the flag state by one request and return the result it produces.
  function automatic flag_result_t apply_request(input logic [OP_W-1:0] op,
                                                 input logic [FLAG_WIDTH-1:0] m,
                                                 input logic consume);
    flag_result_t r;
    logic [FLAG_WIDTH-1:0] w;
    int i;
    r = '0;
    case (op)
      OP_RAISE: begin
        chg_set  = chg_set | m;
        chg_keep = chg_keep | m;
      end
      OP_DROP: begin
        chg_set  = chg_set & ~m;
        chg_keep = chg_keep & ~m;
      end
      OP_FORCE: begin
        flag_word = m;
        chg_keep  = '1;
        chg_set   = '0;
      end
      OP_LISTEN: begin
        w = flag_word;
        // Walk the table in order; a consuming event hides its bits from later ones.
        for (i = 0; i < NUM_EVENTS; i++) begin
          if (ev_mask[i] != '0 && (w & ev_mask[i]) == ev_mask[i]) begin
            r.fired[i] = 1'b1;
            if (ev_consume[i])
              w = w & ~ev_mask[i];
          end
        end
        flag_word = (w & chg_keep) | chg_set;
        chg_keep  = '1;
        chg_set   = '0;
      end
      OP_CHECK: begin
        if (m != '0 && (flag_word & m) == m) begin
          r.single_hit = 1'b1;
          if (consume)
            flag_word = flag_word & ~m;
        end
        chg_keep = '1;
        chg_set  = '0;
      end
      OP_SNOOP: begin
        r.snoop_hit = ((flag_word & m) == m);
      end
      default: ;
    endcase
    r.flags = flag_word;
    return r;
  endfunction

  always @(posedge clk) begin : watch
    flag_result_t want;
    int i;
    if (!rst_n) begin
      for (i = 0; i < EVENT_SLOTS; i++)
        ev_mask[i] = '0;
      ev_consume = '0;
      flag_word  = '0;
      chg_keep   = '1;
      chg_set    = '0;
      awaited.delete();
    end else begin
      if (cfg_wen) begin
        if (cfg_index < EVENT_SLOTS)
          ev_mask[cfg_index] = cfg_wdata;
        else if (cfg_index == REG_EVENT_CONSUMES)
          ev_consume = cfg_wdata[EVENT_SLOTS-1:0];
      end
      if (in_valid && !in_stall)
        awaited.push_back(apply_request(in_operation, in_operand_mask, in_consume));
      if (out_valid && !out_stall) begin
        if (awaited.size() == 0) begin
          note_fault("unexpected result, flags_out", '0, out_flags_out);
        end else begin
          want = awaited.pop_front();
          results_seen++;
          if (want.flags !== out_flags_out)
            note_fault("flags_out", want.flags, out_flags_out);
          if (want.fired !== out_fired)
            note_fault("fired", FLAG_WIDTH'(want.fired), FLAG_WIDTH'(out_fired));
          if (want.single_hit !== out_single_fired)
            note_fault("single_fired", FLAG_WIDTH'(want.single_hit),
                       FLAG_WIDTH'(out_single_fired));
          if (want.snoop_hit !== out_snoop_hit)
            note_fault("snoop_hit", FLAG_WIDTH'(want.snoop_hit), FLAG_WIDTH'(out_snoop_hit));
        end
      end
    end
    fail_cnt <= faults;
    done_cnt <= results_seen;
    open_cnt <= awaited.size();
  end

endmodule

>>> test/event_flag_matcher_tb.sv
// Testbench top for the event flag matcher: clock, reset, config writes and request stimulus.
// Depends on efm_pkg, event_flag_matcher and efm_checker, which judges every result.
`timescale 1ns / 1ps

module event_flag_matcher_tb;
  import efm_pkg::*;

  localparam int FW = FLAG_WIDTH_DEF;

  logic                   clk;
  logic                   rst_n = 1'b0;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  logic [OP_W-1:0]        in_operation = '0;
  logic [FW-1:0]          in_operand_mask = '0;
  logic                   in_consume = 1'b0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic [FW-1:0]          out_flags_out;
  logic [EVENT_SLOTS-1:0] out_fired;
  logic                   out_single_fired;
  logic                   out_snoop_hit;
  logic                   cfg_wen = 1'b0;
  logic [IDX_W-1:0]       cfg_index = '0;
  logic [FW-1:0]          cfg_wdata = '0;

  int unsigned fail_cnt;
  int unsigned done_cnt;
  int unsigned open_cnt;

  int unsigned sent_cnt = 0;
  bit          calm = 1'b0;
  int unsigned hot_base = 0;
  logic [FW-1:0] ev_cfg [EVENT_SLOTS];

  event_flag_matcher dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_operation     (in_operation),
    .in_operand_mask  (in_operand_mask),
    .in_consume       (in_consume),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_flags_out    (out_flags_out),
    .out_fired        (out_fired),
    .out_single_fired (out_single_fired),
    .out_snoop_hit    (out_snoop_hit),
    .cfg_wen          (cfg_wen),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  efm_checker chk (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_operation     (in_operation),
    .in_operand_mask  (in_operand_mask),
    .in_consume       (in_consume),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_flags_out    (out_flags_out),
    .out_fired        (out_fired),
    .out_single_fired (out_single_fired),
    .out_snoop_hit    (out_snoop_hit),
    .cfg_wen          (cfg_wen),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .fail_cnt         (fail_cnt),
    .done_cnt         (done_cnt),
    .open_cnt         (open_cnt)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst_n)
      out_stall <= 1'b0;
    else
      out_stall <= !calm && ($urandom_range(99) < 9);
  end

  // Present one request and hold it until it transfers.
  task automatic send_item(input logic [OP_W-1:0] op, input logic [FW-1:0] m, input logic c);
    while (!calm && $urandom_range(99) < 9) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_operation    <= op;
    in_operand_mask <= m;
    in_consume      <= c;
    do @(posedge clk); while (in_stall);
    sent_cnt++;
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [FW-1:0] val);
    cfg_wen   <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  // Drop valid and hold until every transfer has produced its result.
  task automatic drain();
    in_valid <= 1'b0;
    while (done_cnt != sent_cnt) @(posedge clk);
  endtask

  function automatic logic [FW-1:0] hot_bits();
    logic [FW-1:0] m;
    int unsigned k;
    m = '0;
    k = $urandom_range(4, 1);
    repeat (k) m[hot_base + $urandom_range(15)] = 1'b1;
    return m;
  endfunction

  function automatic logic [FW-1:0] pick_event_mask();
    int unsigned sel;
    int unsigned len;
    sel = $urandom_range(99);
    len = $urandom_range(16, 1);
    if (sel < 45) return hot_bits();
    else if (sel < 58) return FW'(1) << (hot_base + $urandom_range(15));
    else if (sel < 70) return {$urandom, $urandom};
    else if (sel < 82) return ({FW{1'b1}} >> (FW - len)) << (hot_base + $urandom_range(15));
    else if (sel < 91) return '0;
    else return '1;
  endfunction

  function automatic logic [FW-1:0] pick_operand();
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 35) return ev_cfg[$urandom_range(EVENT_SLOTS-1)];
    else if (sel < 50)
      return ev_cfg[$urandom_range(EVENT_SLOTS-1)] | ev_cfg[$urandom_range(EVENT_SLOTS-1)];
    else if (sel < 65) return hot_bits();
    else if (sel < 80) return {$urandom, $urandom};
    else if (sel < 88) return FW'(1) << $urandom_range(FW-1);
    else if (sel < 94) return '1;
    else return '0;
  endfunction

  // Load all event registers, the consume bits and the unmapped index.
  task automatic load_table(input int mode, input logic [EVENT_SLOTS-1:0] cons);
    int i;
    hot_base = $urandom_range(FW - 16);
    for (i = 0; i < EVENT_SLOTS; i++) begin
      case (mode)
        1:       ev_cfg[i] = '1;
        2:       ev_cfg[i] = '0;
        default: ev_cfg[i] = pick_event_mask();
      endcase
      write_reg(IDX_W'(i), ev_cfg[i]);
    end
    write_reg(REG_EVENT_CONSUMES, {$urandom, 26'($urandom_range(2**26 - 1)), cons});
    write_reg(REG_EVENT_CONSUMES + 1'b1, {$urandom, $urandom});
    cfg_wen <= 1'b0;
  endtask

  task automatic run_phase(input int unsigned n);
    int unsigned cnt;
    int unsigned k;
    logic [OP_W-1:0] op;
    cnt = 0;
    while (cnt < n) begin
      if ($urandom_range(99) < 75) begin
        if ($urandom_range(9) == 0) begin
          send_item(OP_FORCE, pick_operand(), 1'($urandom_range(1)));
          cnt++;
        end
        k = $urandom_range(3);
        repeat (k) begin
          op = ($urandom_range(99) < 70) ? OP_RAISE : OP_DROP;
          send_item(op, pick_operand(), 1'($urandom_range(1)));
          cnt++;
        end
        if ($urandom_range(9) < 7)
          send_item(OP_LISTEN, pick_operand(), 1'($urandom_range(1)));
        else
          send_item(OP_CHECK, pick_operand(), 1'($urandom_range(1)));
        cnt++;
        if ($urandom_range(1)) begin
          send_item(OP_SNOOP, pick_operand(), 1'($urandom_range(1)));
          cnt++;
        end
      end else begin
        op = OP_W'($urandom_range(7));
        send_item(op, pick_operand(), 1'($urandom_range(1)));
        cnt++;
      end
    end
    drain();
  endtask

  initial begin
    int p;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed table: single low bit, top bit, full word, disabled slot, overlaps.
    ev_cfg[0] = 64'h1;
    ev_cfg[1] = 64'h8000_0000_0000_0000;
    ev_cfg[2] = '1;
    ev_cfg[3] = '0;
    ev_cfg[4] = 64'h3;
    ev_cfg[5] = 64'hF0;
    for (p = 0; p < EVENT_SLOTS; p++)
      write_reg(IDX_W'(p), ev_cfg[p]);
    write_reg(REG_EVENT_CONSUMES, {58'h3FF_FFFF_FFFF_FFFF, 6'b010001});
    cfg_wen <= 1'b0;

    send_item(OP_SNOOP, '0, 1'b0);                  // empty query always hits
    send_item(OP_SNOOP, '1, 1'b1);
    send_item(OP_LISTEN, '0, 1'b0);
    send_item(OP_CHECK, '0, 1'b1);                  // empty check never fires
    send_item(OP_RAISE, 64'h1, 1'b0);
    send_item(OP_RAISE, 64'h8000_0000_0000_0000, 1'b0);
    send_item(OP_LISTEN, '0, 1'b0);                 // change lands after the walk
    send_item(OP_LISTEN, '1, 1'b0);
    send_item(OP_FORCE, '1, 1'b0);
    send_item(OP_LISTEN, '0, 1'b0);                 // event 0 consumes bit 0 ahead of 2 and 4
    send_item(OP_FORCE, '1, 1'b0);
    send_item(OP_RAISE, '0, 1'b0);
    send_item(OP_DROP, 64'hF0, 1'b0);
    send_item(OP_CHECK, 64'h3, 1'b1);               // fires, clears, discards the drop
    send_item(OP_SNOOP, 64'hF0, 1'b0);
    send_item(OP_DROP, '1, 1'b0);
    send_item(OP_LISTEN, '0, 1'b1);
    send_item(OP_FORCE, 64'hAAAA_AAAA_AAAA_AAAA, 1'b1);
    send_item(OP_CHECK, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0);
    send_item(3'd6, '1, 1'b1);
    send_item(3'd7, 64'h5555_5555_5555_5555, 1'b0);
    send_item(OP_RAISE, 64'hFF, 1'b0);
    send_item(OP_DROP, 64'h0F, 1'b0);
    send_item(OP_RAISE, 64'h01, 1'b0);
    send_item(OP_LISTEN, '0, 1'b0);
    drain();

    for (p = 0; p < 11; p++) begin
      case (p)
        0:       load_table(0, '0);
        1:       load_table(0, '1);
        2:       load_table(1, 6'($urandom_range(63)));
        3:       load_table(2, 6'($urandom_range(63)));
        default: load_table(0, 6'($urandom_range(63)));
      endcase
      calm = (p == 6);
      run_phase(150);
    end
    calm = 1'b0;

    repeat (4) @(posedge clk);
    if (fail_cnt == 0 && open_cnt == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
